>>> src/wesc_pkg.sv
`default_nettype none

package wesc_pkg;

    // Event kinds carried in the input tuser field.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LEFT  = 2'd1;
    localparam logic [1:0] OP_RIGHT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_HOLE_PITCH  = 2'd0;
    localparam logic [1:0] REG_SPEED_CONST = 2'd1;
    localparam logic [1:0] REG_PER_CAPTURE = 2'd2;

    localparam int PITCH_W    = 16;
    localparam int SPEED_W    = 24;
    localparam int PPC_W      = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int RESIDUE_W  = 6;

    localparam logic [PITCH_W-1:0] PITCH_RESET       = 16'd10350;
    localparam logic [SPEED_W-1:0] SPEED_CONST_RESET = 24'd1035288;
    localparam logic [PPC_W-1:0]   PPC_RESET         = 7'd5;
    localparam logic [PPC_W-1:0]   MAX_INTERVAL      = 7'd64;
    localparam logic [SPEED_W-1:0] SPEED_MAX         = 24'hFF_FFFF;

    localparam int OUT_COUNT_W = 32;
    localparam int OUT_DIST_W  = 46;
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_FIELD_W = 2 * OUT_COUNT_W + 2 * OUT_DIST_W + 2 * SPEED_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    typedef struct packed {
        logic tick;
        logic pulse;
        logic up;
    } wheel_evt_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> src/wesc_divider.sv
`default_nettype none

module wesc_divider #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output wesc_pkg::div_status_t      status,
    output logic      [DIVIDEND_W-1:0] quotient
);
    import wesc_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0] shifted;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

>>> src/wesc_wheel.sv
`default_nettype none

module wesc_wheel #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire wesc_pkg::wheel_evt_t   evt,
    input  wire logic [6:0]             interval,
    output logic [COUNT_WIDTH-1:0]      pulses,
    output logic [TIMER_WIDTH-1:0]      period,
    output logic                        speed_valid
);
    import wesc_pkg::*;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    logic [COUNT_WIDTH-1:0] pulses_reg;
    logic [RESIDUE_W-1:0]   residue_reg;
    logic [TIMER_WIDTH-1:0] timer_reg;
    logic [TIMER_WIDTH-1:0] period_reg;
    logic                   valid_reg;

    logic [PPC_W-1:0]     res_ext;
    logic [PPC_W-1:0]     res_inc;
    logic [PPC_W-1:0]     res_dec;
    logic [RESIDUE_W-1:0] residue_next;

    always_comb begin
        res_ext = {1'b0, residue_reg};
        res_inc = res_ext + 1'b1;
        res_dec = res_ext - 1'b1;
        if (evt.up) begin
            residue_next = (res_inc >= interval) ? '0 : res_inc[RESIDUE_W-1:0];
        end else if (residue_reg == '0 || res_dec >= interval) begin
            // Wrap downwards, also when a lowered interval left the residue too high.
            residue_next = RESIDUE_W'(interval - 1'b1);
        end else begin
            residue_next = res_dec[RESIDUE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulses_reg  <= '0;
            residue_reg <= '0;
            timer_reg   <= '0;
            period_reg  <= '0;
            valid_reg   <= 1'b0;
        end else if (evt.tick) begin
            if (timer_reg != TIMER_MAX) begin
                timer_reg <= timer_reg + 1'b1;
            end
        end else if (evt.pulse) begin
            pulses_reg  <= evt.up ? pulses_reg + 1'b1 : pulses_reg - 1'b1;
            residue_reg <= residue_next;
            if (residue_next == '0) begin
                period_reg <= timer_reg;
                timer_reg  <= '0;
                valid_reg  <= 1'b1;
            end
        end
    end

    assign pulses      = pulses_reg;
    assign period      = period_reg;
    assign speed_valid = valid_reg;

endmodule

`default_nettype wire

>>> src/wheel_encoder_speed_capture.sv
`default_nettype none

// Two-wheel encoder capture. Each input beat is one event (timer tick, left
// pulse or right pulse, selected by s_axis_tuser) and yields exactly one output
// beat with both signed pulse counts, both distances in micrometres (saturated
// to 46 bits) and both speeds in mm/s with their valid flags. The block takes
// one event at a time: a new event is accepted only once the previous beat has
// been loaded into the output register. The single 24-step shift-subtract
// divider is used once for each wheel with a captured nonzero period, after one
// shared multiplier has formed both distances. A stalled output holds the block
// in S_OUT until the output register is free. A finished beat waits in the
// output register while the next event is accepted.
// Configuration writes must only be made while the block is idle.
module wheel_encoder_speed_capture #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input beat.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: forward [0], zero padding [7:1].
    input  wire logic [wesc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: opcode [1:0].
    input  wire logic [wesc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    // Result beat.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: left_count [31:0], right_count [63:32], left_distance_um [109:64],
    // right_distance_um [155:110], left_speed_mm_s [179:156],
    // right_speed_mm_s [203:180], zero padding [207:204].
    output logic [wesc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // tuser: left_speed_valid [0], right_speed_valid [1].
    output logic [wesc_pkg::OUT_TUSER_W-1:0]         m_axis_tuser,
    // Configuration writes.
    input  wire logic                                cfg_we,
    input  wire logic [wesc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [wesc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import wesc_pkg::*;

    localparam int PROD_W = COUNT_WIDTH + PITCH_W + 1;
    localparam int SAT_W  = (PROD_W > OUT_DIST_W) ? PROD_W : OUT_DIST_W;
    localparam int PAD_W  = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic signed [SAT_W-1:0] DIST_MAX =
        {{(SAT_W - OUT_DIST_W + 1){1'b0}}, {(OUT_DIST_W - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] DIST_MIN =
        {{(SAT_W - OUT_DIST_W + 1){1'b1}}, {(OUT_DIST_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_SAT_R,
        S_START_L,
        S_WAIT_L,
        S_START_R,
        S_WAIT_R,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [PITCH_W-1:0] pitch_reg;
    logic [SPEED_W-1:0] speed_const_reg;
    logic [PPC_W-1:0]   ppc_reg;
    logic [PPC_W-1:0]   interval;

    logic       in_accept;
    wheel_evt_t evt_l;
    wheel_evt_t evt_r;

    logic [COUNT_WIDTH-1:0] pulses_l;
    logic [COUNT_WIDTH-1:0] pulses_r;
    logic [TIMER_WIDTH-1:0] period_l;
    logic [TIMER_WIDTH-1:0] period_r;
    logic                   valid_l;
    logic                   valid_r;

    logic signed [COUNT_WIDTH-1:0] count_sel;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [SAT_W-1:0]       prod_ext;
    logic        [OUT_DIST_W-1:0]  dist_sat;
    logic        [OUT_DIST_W-1:0]  dist_l_reg;
    logic        [OUT_DIST_W-1:0]  dist_r_reg;
    logic        [SPEED_W-1:0]     speed_l_reg;
    logic        [SPEED_W-1:0]     speed_r_reg;

    logic                   div_start;
    logic [TIMER_WIDTH-1:0] div_divisor;
    logic [SPEED_W-1:0]     quotient;
    div_status_t            div_status;

    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TUSER_W-1:0] m_tuser_reg;
    logic                   m_tvalid_reg;
    logic                   out_free;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg       <= PITCH_RESET;
            speed_const_reg <= SPEED_CONST_RESET;
            ppc_reg         <= PPC_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_HOLE_PITCH:  pitch_reg       <= cfg_wdata[PITCH_W-1:0];
                REG_SPEED_CONST: speed_const_reg <= cfg_wdata[SPEED_W-1:0];
                REG_PER_CAPTURE: ppc_reg         <= cfg_wdata[PPC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (ppc_reg == '0) begin
            interval = PPC_W'(1);
        end else if (ppc_reg > MAX_INTERVAL) begin
            interval = MAX_INTERVAL;
        end else begin
            interval = ppc_reg;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        evt_l.tick  = in_accept && (s_axis_tuser == OP_TICK);
        evt_l.pulse = in_accept && (s_axis_tuser == OP_LEFT);
        evt_l.up    = s_axis_tdata[0];
        evt_r.tick  = evt_l.tick;
        evt_r.pulse = in_accept && (s_axis_tuser == OP_RIGHT);
        evt_r.up    = s_axis_tdata[0];
    end

    wesc_wheel #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_wheel_l (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .evt         (evt_l),
        .interval    (interval),
        .pulses      (pulses_l),
        .period      (period_l),
        .speed_valid (valid_l)
    );

    wesc_wheel #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_wheel_r (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .evt         (evt_r),
        .interval    (interval),
        .pulses      (pulses_r),
        .period      (period_r),
        .speed_valid (valid_r)
    );

    // One multiplier serves both wheels; its product is registered in prod_reg and saturated from that register.
    always_comb begin
        count_sel = (state_reg == S_MUL_L) ? $signed(pulses_l) : $signed(pulses_r);
        prod      = PROD_W'(count_sel) * PROD_W'($signed({1'b0, pitch_reg}));
        prod_ext  = SAT_W'(prod_reg);
        if (prod_ext > DIST_MAX) begin
            dist_sat = DIST_MAX[OUT_DIST_W-1:0];
        end else if (prod_ext < DIST_MIN) begin
            dist_sat = DIST_MIN[OUT_DIST_W-1:0];
        end else begin
            dist_sat = prod_ext[OUT_DIST_W-1:0];
        end
    end

    always_comb begin
        div_start   = 1'b0;
        div_divisor = period_r;
        if (state_reg == S_START_L) begin
            div_start   = valid_l && (period_l != '0);
            div_divisor = period_l;
        end else if (state_reg == S_START_R) begin
            div_start   = valid_r && (period_r != '0);
        end
    end

    wesc_divider #(
        .DIVIDEND_W (SPEED_W),
        .DIVISOR_W  (TIMER_WIDTH)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (speed_const_reg),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (quotient)
    );

    assign out_free = !m_tvalid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // In S_OUT a free output register is reloaded below instead.
            if (m_axis_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        state_reg <= S_MUL_L;
                    end
                end
                S_MUL_L: begin
                    prod_reg  <= prod;
                    state_reg <= S_MUL_R;
                end
                S_MUL_R: begin
                    prod_reg   <= prod;
                    dist_l_reg <= dist_sat;
                    state_reg  <= S_SAT_R;
                end
                S_SAT_R: begin
                    dist_r_reg <= dist_sat;
                    state_reg  <= S_START_L;
                end
                S_START_L: begin
                    if (div_start) begin
                        state_reg <= S_WAIT_L;
                    end else begin
                        // A captured period of zero reads as full-scale speed.
                        speed_l_reg <= valid_l ? SPEED_MAX : '0;
                        state_reg   <= S_START_R;
                    end
                end
                S_WAIT_L: begin
                    if (div_status.done) begin
                        speed_l_reg <= quotient;
                        state_reg   <= S_START_R;
                    end
                end
                S_START_R: begin
                    if (div_start) begin
                        state_reg <= S_WAIT_R;
                    end else begin
                        speed_r_reg <= valid_r ? SPEED_MAX : '0;
                        state_reg   <= S_OUT;
                    end
                end
                S_WAIT_R: begin
                    if (div_status.done) begin
                        speed_r_reg <= quotient;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tdata_reg <= {{PAD_W{1'b0}}, speed_r_reg, speed_l_reg,
                                        dist_r_reg, dist_l_reg,
                                        OUT_COUNT_W'($signed(pulses_r)),
                                        OUT_COUNT_W'($signed(pulses_l))};
                        m_tuser_reg  <= {valid_r, valid_l};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // The divider only runs while the block holds an item.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !div_status.busy)
        else $error("divider busy while accepting events");

    // An accepted event always takes the block out of idle, so s_axis_tready drops after the accept.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second event accepted straight after the first");

    // A quotient is only ever delivered to a state that waits for it.
    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == S_WAIT_L || state_reg == S_WAIT_R))
        else $error("divider finished with nobody waiting");

    // The left wheel without a captured period reports zero speed.
    a_speed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[179:156] == '0))
        else $error("left speed reported before any capture");

endmodule

`default_nettype wire
